>>> rtl/core/assert_macros.svh
// Assertion macros shared by the heapsort RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hs_pkg.sv
// Package for the heapsort block: controller states, command and status bundles.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package hs_pkg;

  localparam int CMP_W = 12;
  localparam logic [CMP_W-1:0] CMP_MAX = 12'hFFF;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD_INIT,
    ST_BUILD_NEXT,
    ST_BUILD_LD,
    ST_SORT_NEXT,
    ST_SORT_LD1,
    ST_SORT_LD2,
    ST_LEFT,
    ST_RIGHT,
    ST_CMPR,
    ST_MOVE,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic build_init;
    logic sort_init;
    logic emit_init;
    logic rd_im1;
    logic rd_zero;
    logic load_v;
    logic sort_swap;
    logic rd_left;
    logic take_left;
    logic take_right;
    logic move;
    logic place;
    logic rd_k;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic i_zero;
    logic left_ok;
    logic right_ok;
    logic top_is_pos;
    logic out_taken;
    logic out_final;
  } st_t;

endpackage

`default_nettype wire

>>> rtl/core/hs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/hs_ctrl.sv
// Heapsort controller: sequences load, heap build, sort-down and emission.
// Depends on hs_pkg; drives the datapath through cmd_t, reads st_t.
`default_nettype none

module hs_ctrl
  import hs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire st_t  st,
  output cmd_t      cmd
);

  state_t state, state_next;
  logic   sorting, sorting_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      sorting <= 1'b0;
    end else begin
      state   <= state_next;
      sorting <= sorting_next;
    end
  end

  always_comb begin
    state_next   = state;
    sorting_next = sorting;
    unique case (state)
      ST_LOAD: begin
        if (st.in_fire && st.in_last) begin
          state_next = ST_BUILD_INIT;
        end
      end
      ST_BUILD_INIT: begin
        state_next   = ST_BUILD_NEXT;
        sorting_next = 1'b0;
      end
      ST_BUILD_NEXT: begin
        if (st.i_zero) begin
          state_next   = ST_SORT_NEXT;
          sorting_next = 1'b1;
        end else begin
          state_next = ST_BUILD_LD;
        end
      end
      ST_BUILD_LD: state_next = ST_LEFT;
      ST_SORT_NEXT: begin
        state_next = st.i_zero ? ST_EMIT_RD : ST_SORT_LD1;
      end
      ST_SORT_LD1: state_next = ST_SORT_LD2;
      ST_SORT_LD2: state_next = ST_LEFT;
      ST_LEFT:     state_next = st.left_ok ? ST_RIGHT : ST_PLACE;
      ST_RIGHT:    state_next = st.right_ok ? ST_CMPR : ST_MOVE;
      ST_CMPR:     state_next = ST_MOVE;
      ST_MOVE:     state_next = st.top_is_pos ? ST_PLACE : ST_LEFT;
      ST_PLACE:    state_next = sorting ? ST_SORT_NEXT : ST_BUILD_NEXT;
      ST_EMIT_RD:  state_next = ST_EMIT_LD;
      ST_EMIT_LD:  state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (st.out_taken) begin
          state_next = st.out_final ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_LOAD:       cmd.accept = !rst;
      ST_BUILD_INIT: cmd.build_init = 1'b1;
      ST_BUILD_NEXT: begin
        if (st.i_zero) begin
          cmd.sort_init = 1'b1;
        end else begin
          cmd.rd_im1 = 1'b1;
        end
      end
      ST_BUILD_LD:   cmd.load_v = 1'b1;
      ST_SORT_NEXT: begin
        if (st.i_zero) begin
          cmd.emit_init = 1'b1;
        end else begin
          cmd.rd_im1 = 1'b1;
        end
      end
      ST_SORT_LD1: begin
        cmd.load_v  = 1'b1;
        cmd.rd_zero = 1'b1;
      end
      ST_SORT_LD2:   cmd.sort_swap = 1'b1;
      ST_LEFT:       cmd.rd_left = 1'b1;
      ST_RIGHT:      cmd.take_left = 1'b1;
      ST_CMPR:       cmd.take_right = 1'b1;
      ST_MOVE:       cmd.move = !st.top_is_pos;
      ST_PLACE:      cmd.place = 1'b1;
      ST_EMIT_RD:    cmd.rd_k = 1'b1;
      ST_EMIT_LD:    cmd.out_load = 1'b1;
      ST_EMIT_WAIT:  cmd = '0;
      default:       cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/hs_datapath.sv
// Heapsort datapath: element RAM, heap indices, sift registers, counters, output item.
// Depends on hs_pkg and hs_ram; commanded by hs_ctrl.
`default_nettype none

`include "assert_macros.svh"

module hs_datapath
  import hs_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64,
  parameter int DATA_WIDTH   = 32,
  localparam int SDW = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int TDW = ((DATA_WIDTH + CMP_W + 1 + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cmd_t           cmd,
  output st_t                 st,
  input  wire logic           s_tvalid,
  input  wire logic [SDW-1:0] s_tdata,
  input  wire logic           s_tlast,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic      [TDW-1:0] m_tdata,
  output logic                m_tlast
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = AW + 2;

  logic [CW-1:0]         count;
  logic [CW-1:0]         i;
  logic [CW-1:0]         hn;
  logic [AW-1:0]         pos;
  logic [AW-1:0]         top_idx;
  logic [AW-1:0]         k;
  logic [DATA_WIDTH-1:0] v;
  logic [DATA_WIDTH-1:0] best;
  logic [CMP_W-1:0]      cmp;
  logic                  ovf;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic [IW-1:0]         left_idx;
  logic [IW-1:0]         right_idx;
  logic [CW-1:0]         im1;
  logic                  full;
  logic                  in_fire;
  logic                  out_take;
  logic                  k_last;
  logic [CMP_W-1:0]      cmp_inc;

  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = left_idx + IW'(1);
  assign im1       = i - CW'(1);
  assign full      = (count == CW'(MAX_ELEMENTS));
  assign in_fire   = s_tvalid && cmd.accept;
  assign out_take  = m_tvalid && m_tready;
  assign k_last    = ((CW'(k) + CW'(1)) == count);
  assign cmp_inc   = (cmp == CMP_MAX) ? cmp : cmp + CMP_W'(1);

  assign st.in_fire    = in_fire;
  assign st.in_last    = s_tlast;
  assign st.i_zero     = (i == '0);
  assign st.left_ok    = (left_idx < IW'(hn));
  assign st.right_ok   = (right_idx < IW'(hn));
  assign st.top_is_pos = (top_idx == pos);
  assign st.out_taken  = out_take;
  assign st.out_final  = m_tlast;

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = v;
    priority if (in_fire && !full) begin
      we    = 1'b1;
      waddr = count[AW-1:0];
      wdata = s_tdata[DATA_WIDTH-1:0];
    end else if (cmd.sort_swap) begin
      we    = 1'b1;
      waddr = im1[AW-1:0];
      wdata = rdata;
    end else if (cmd.move) begin
      we    = 1'b1;
      wdata = best;
    end else if (cmd.place) begin
      we    = 1'b1;
    end else begin
      we    = 1'b0;
    end
  end

  always_comb begin
    raddr = '0;
    priority if (cmd.rd_im1) begin
      raddr = im1[AW-1:0];
    end else if (cmd.rd_zero) begin
      raddr = '0;
    end else if (cmd.rd_left) begin
      raddr = left_idx[AW-1:0];
    end else if (cmd.take_left) begin
      raddr = right_idx[AW-1:0];
    end else if (cmd.rd_k) begin
      raddr = k;
    end else begin
      raddr = '0;
    end
  end

  hs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      cmp      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.build_init) begin
        cmp <= '0;
      end
      if (cmd.take_left || cmd.take_right) begin
        cmp <= cmp_inc;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (out_take) begin
        m_tvalid <= 1'b0;
        if (m_tlast) begin
          count <= '0;
          cmp   <= '0;
          ovf   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      hn <= count;
      i  <= count >> 1;
    end
    if (cmd.sort_init) begin
      i <= hn;
    end
    if (cmd.rd_im1) begin
      pos <= im1[AW-1:0];
    end
    if (cmd.load_v) begin
      v <= rdata;
    end
    if (cmd.sort_swap) begin
      hn  <= im1;
      pos <= '0;
    end
    if (cmd.take_left) begin
      if ($signed(rdata) > $signed(v)) begin
        best    <= rdata;
        top_idx <= left_idx[AW-1:0];
      end else begin
        best    <= v;
        top_idx <= pos;
      end
    end
    if (cmd.take_right && ($signed(rdata) > $signed(best))) begin
      best    <= rdata;
      top_idx <= right_idx[AW-1:0];
    end
    if (cmd.move) begin
      pos <= top_idx;
    end
    if (cmd.place) begin
      i <= im1;
    end
    if (cmd.emit_init) begin
      k <= '0;
    end else if (out_take) begin
      k <= k + AW'(1);
    end
    if (cmd.out_load) begin
      m_tdata <= TDW'({ovf, cmp, rdata});
      m_tlast <= k_last;
    end
  end

  `HS_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(MAX_ELEMENTS), "element count past capacity")
  `HS_ASSERT_NOW(a_left_exists, cmd.take_left, left_idx < IW'(hn), "left child outside heap")
  `HS_ASSERT_NEXT(a_run_clear, out_take && m_tlast, count == '0 && cmp == '0 && !ovf,
                  "run state not cleared after final item")

endmodule

`default_nettype wire

>>> rtl/core/heap_sort_with_comparison_count.sv
// Heapsort block with comparison count: top level joining controller and datapath.
// Depends on hs_pkg, hs_ctrl, hs_datapath (and hs_ram below it).
//
// Usage:
//   Slave channel s_*: one signed word per item in s_tdata, s_tlast marks the final
//   word of a set. Loading takes one cycle per item. Items past MAX_ELEMENTS are
//   dropped and the overflow flag is raised for the run.
//   After the item marked last, s_tready stays low while the block sorts. The heap
//   lives in a single RAM with one read and one write port.
//   Master channel m_*: one item per sorted word, smallest first, each carrying the
//   comparison total and overflow flag; m_tlast marks the final word. Emission
//   reads each word into the output register and waits until it is taken.
//   A stalled item holds in the output register until m_tready; the block accepts
//   no new input until the final result of the run has been taken.
//   Reset returns the block to loading with an empty set; the element RAM is not
//   cleared and needs no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module heap_sort_with_comparison_count
  import hs_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64,
  parameter int DATA_WIDTH   = 32,
  localparam int SDW = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int TDW = ((DATA_WIDTH + CMP_W + 1 + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [SDW-1:0] s_tdata,   // value
  input  wire logic           s_tlast,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic      [TDW-1:0] m_tdata,   // sorted_value, comparisons, overflowed
  output logic                m_tlast
);

  cmd_t cmd;
  st_t  st;

  hs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  hs_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  assign s_tready = cmd.accept;

  `HS_ASSERT_NOW(a_no_load_while_out, s_tready, !m_tvalid, "input open while result pending")

endmodule

`default_nettype wire
